[rtl/jse_pkg.sv]
// Shared types, constants and helpers for the JSON string escaper.
`default_nettype none

package jse_pkg;

   // ASCII codes used by the escaper
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LOW_B     = 8'h62;
   localparam logic [7:0] CH_LOW_T     = 8'h74;
   localparam logic [7:0] CH_LOW_N     = 8'h6E;
   localparam logic [7:0] CH_LOW_F     = 8'h66;
   localparam logic [7:0] CH_LOW_R     = 8'h72;
   localparam logic [7:0] CH_LOW_U     = 8'h75;
   localparam logic [7:0] CH_DIGIT0    = 8'h30;
   localparam logic [7:0] CTRL_LIMIT   = 8'h20;

   localparam logic [7:0] HEX_DIGITS [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
   };

   localparam int CountWidth = 16;
   localparam int StepWidth  = 3;

   // Escape lengths
   localparam logic [StepWidth-1:0] LEN_PASS    = 3'd1;
   localparam logic [StepWidth-1:0] LEN_SHORT   = 3'd2;
   localparam logic [StepWidth-1:0] LEN_UNICODE = 3'd6;

   // Positions inside a unicode escape
   localparam logic [StepWidth-1:0] STEP_LEAD = 3'd0;
   localparam logic [StepWidth-1:0] STEP_U    = 3'd1;
   localparam logic [StepWidth-1:0] STEP_Z0   = 3'd2;
   localparam logic [StepWidth-1:0] STEP_Z1   = 3'd3;
   localparam logic [StepWidth-1:0] STEP_HI   = 3'd4;
   localparam logic [StepWidth-1:0] STEP_LO   = 3'd5;

   typedef enum logic [1:0] {
      KIND_PASS,
      KIND_SHORT,
      KIND_UNICODE
   } kind_type;

   // Queue entry: kind plus the source byte (or escape letter for short escapes)
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } entry_type;

   // Front-end status exported for checking
   typedef struct packed {
      logic                  push;
      logic [CountWidth-1:0] count;
      logic [CountWidth-1:0] limit;
   } front_status_type;

   // Queue status
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic entry_type classify(input logic [7:0] c);
      entry_type e;
      e.data = c;
      e.kind = KIND_PASS;
      unique case (c)
         CH_BACKSLASH: e.kind = KIND_SHORT;
         CH_QUOTE:     e.kind = KIND_SHORT;
         CH_BS:  begin e.kind = KIND_SHORT; e.data = CH_LOW_B; end
         CH_TAB: begin e.kind = KIND_SHORT; e.data = CH_LOW_T; end
         CH_LF:  begin e.kind = KIND_SHORT; e.data = CH_LOW_N; end
         CH_FF:  begin e.kind = KIND_SHORT; e.data = CH_LOW_F; end
         CH_CR:  begin e.kind = KIND_SHORT; e.data = CH_LOW_R; end
         default: begin
            if (c < CTRL_LIMIT) begin
               e.kind = KIND_UNICODE;
            end
         end
      endcase
      return e;
   endfunction

   function automatic logic [StepWidth-1:0] esc_len(input kind_type k);
      logic [StepWidth-1:0] n;
      unique case (k)
         KIND_SHORT:   n = LEN_SHORT;
         KIND_UNICODE: n = LEN_UNICODE;
         default:      n = LEN_PASS;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

[rtl/jse_front.sv]
// Front end: takes input beats, classifies them and applies the output limit.
`default_nettype none

module jse_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_char_byte,
   input  wire logic                           req_first_of_string,
   input  wire logic                           csr_wr_en,
   input  wire logic [jse_pkg::CountWidth-1:0] csr_wr_data,
   input  wire logic                           q_full,
   output jse_pkg::entry_type                  push_entry,
   output jse_pkg::front_status_type           status
);
   import jse_pkg::*;

   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] limit_ff, limit_in;
   logic                  stopped_ff, stopped_in;

   logic [CountWidth-1:0] eff_count;
   logic                  eff_stop;
   logic [StepWidth-1:0]  len;
   logic [CountWidth:0]   sum;
   logic                  fits;
   logic                  accept;

   always_comb begin
      push_entry = classify(req_char_byte);
      len        = esc_len(push_entry.kind);
      eff_count  = req_first_of_string ? '0 : count_ff;
      eff_stop   = req_first_of_string ? 1'b0 : stopped_ff;
      sum        = {1'b0, eff_count} + (CountWidth+1)'(len);
      // a byte at or past the limit also fails here, since len >= 1
      fits       = !eff_stop && (sum <= {1'b0, limit_ff});
      accept     = req_valid && req_ready;

      count_in   = count_ff;
      stopped_in = stopped_ff;
      if (accept) begin
         if (fits) begin
            count_in   = sum[CountWidth-1:0];
            stopped_in = 1'b0;
         end else begin
            count_in   = eff_count;
            stopped_in = 1'b1;
         end
      end
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
   end

   assign req_ready    = !q_full;
   assign status.push  = accept && fits;
   assign status.count = count_ff;
   assign status.limit = limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         stopped_ff <= 1'b0;
         limit_ff   <= CountWidth'(255);
      end else begin
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         limit_ff   <= limit_in;
      end
   end

endmodule

`default_nettype wire

[rtl/jse_queue.sv]
// Small FIFO of classified entries between front and back end.
`default_nettype none

module jse_queue #(
   parameter int Depth = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  jse_pkg::entry_type        push_entry,
   input  wire logic                 pop,
   output jse_pkg::entry_type        head,
   output jse_pkg::queue_status_type status
);
   import jse_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int LvlWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

   entry_type             slots [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LvlWidth-1:0]   level_ff, level_in;
   logic                  do_push, do_pop;

   always_comb begin
      status.empty = (level_ff == '0);
      status.full  = (level_ff == LvlWidth'(Depth));
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      level_in = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   assign head = slots[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

`default_nettype wire

[rtl/jse_back.sv]
// Back end: expands one queue entry into its escaped bytes, one beat a cycle while rsp_ready allows.
`default_nettype none

module jse_back (
   input  wire logic           clock,
   input  wire logic           reset,
   input  jse_pkg::entry_type  head,
   input  wire logic           head_valid,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_run
);
   import jse_pkg::*;

   logic [StepWidth-1:0] step_ff, step_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 load;

   always_comb begin
      load    = head_valid && (!valid_ff || rsp_ready);
      last_in = (step_ff == esc_len(head.kind) - 1'b1);
      unique case (head.kind)
         KIND_SHORT: byte_in = (step_ff == STEP_LEAD) ? CH_BACKSLASH : head.data;
         KIND_UNICODE: begin
            unique case (step_ff)
               STEP_LEAD: byte_in = CH_BACKSLASH;
               STEP_U:    byte_in = CH_LOW_U;
               STEP_Z0:   byte_in = CH_DIGIT0;
               STEP_Z1:   byte_in = CH_DIGIT0;
               STEP_HI:   byte_in = HEX_DIGITS[head.data[7:4]];
               STEP_LO:   byte_in = HEX_DIGITS[head.data[3:0]];
               default:   byte_in = CH_DIGIT0;
            endcase
         end
         default: byte_in = head.data;
      endcase

      pop      = load && last_in;
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = last_in ? '0 : step_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

[rtl/json_string_escaper.sv]
// JSON string escaper top level: front end, entry queue and output serializer.
//
// Bytes of a string come in on the req_ channel and leave JSON-escaped on the
// rsp_ channel. Backslash and double quote gain a backslash; backspace, tab,
// newline, form feed and carriage return become two-byte escapes; other bytes
// below 0x20 become \u00xx with lower-case hex; all else passes through. Each
// input beat yields one to six output beats, the last flagged by
// rsp_last_of_run, or none once the string is cut off. A string is cut off
// when the emitted count reaches the limit in csr_wr_data, or when a whole
// escape would not fit; req_first_of_string starts a new string and clears
// the count and cut-off. The limit resets to 255 and should be written only
// while the block is idle. Rate: plain text streams at one beat per cycle
// while rsp_ready stays high, since the serializer emits one byte per cycle;
// a short or unicode escape holds the output until all its bytes are out. The
// front end keeps taking input during that time until the QueueDepth-entry
// queue fills, then req_ready drops.
`default_nettype none

module json_string_escaper #(
   parameter int QueueDepth = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_first_of_string,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import jse_pkg::*;

   entry_type        push_entry;
   entry_type        head;
   front_status_type front_status;
   queue_status_type q_status;
   logic             pop;

   // classify and apply the limit
   jse_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_char_byte       (req_char_byte),
      .req_first_of_string (req_first_of_string),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .q_full              (q_status.full),
      .push_entry          (push_entry),
      .status              (front_status)
   );

   // decouples classification from serialization
   jse_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_status.push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // one escaped byte per beat, registered output
   jse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (!q_status.empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // emitted count never passes the limit that was in force
   assert property (@(posedge clock) disable iff (reset)
      front_status.push |=> (front_status.count <= $past(front_status.limit)))
      else $error("output count exceeded limit");

   // a waiting entry reaches an empty output register next cycle
   assert property (@(posedge clock) disable iff (reset)
      (!q_status.empty && !rsp_valid) |=> rsp_valid)
      else $error("serializer failed to load waiting entry");

   // input is refused only while the queue is full
   assert property (@(posedge clock) disable iff (reset)
      (req_ready == !q_status.full) && !(q_status.full && q_status.empty))
      else $error("queue flow control inconsistent");

endmodule

`default_nettype wire
